[rtl/variable_length_ring_buffer_core_defines.svh]
// ----------------------------------------------------------------------------
// variable_length_ring_buffer_core_defines.svh
// Assertion macros shared by the ring buffer checker.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_LENGTH_RING_BUFFER_CORE_DEFINES_SVH
`define VARIABLE_LENGTH_RING_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define VLRB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define VLRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/vlrb_pkg.sv]
// ----------------------------------------------------------------------------
// vlrb_pkg
// Constants, codes and the state record of the variable-length ring buffer.
// ----------------------------------------------------------------------------
package vlrb_pkg;

	// Ring geometry
	localparam int BUF_BYTES   = 4096;
	localparam int ALIGN_BYTES = 8;

	// Field widths
	localparam int FUNC_W   = 2;
	localparam int BYTES_W  = 13;
	localparam int STATUS_W = 3;
	localparam int OFFSET_W = 12;
	localparam int FILL_W   = 13;
	localparam int DONE_W   = 16;

	// Pointer width holds 0..BUF_BYTES; sums get two guard bits
	localparam int PTR_W = $clog2(BUF_BYTES + 1);
	localparam int SUM_W = ((PTR_W > BYTES_W) ? PTR_W : BYTES_W) + 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_ACQUIRE = 2'd0,
		FN_SUBMIT  = 2'd1,
		FN_PEEK    = 2'd2,
		FN_CONSUME = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL_WAIT = 3'd1,
		ST_FULL_DROP = 3'd2,
		ST_TERM      = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_OVERSIZE  = 3'd5
	} status_t;

	// Ring bookkeeping state
	typedef struct packed {
		logic [PTR_W-1:0]  wr_off;
		logic [PTR_W-1:0]  rd_off;
		logic [FILL_W-1:0] fill;
		logic              halted;
		logic              mk_valid;
		logic [PTR_W-1:0]  mk_off;
		logic [DONE_W-1:0] done;
	} vlrb_state_t;

endpackage

[rtl/vlrb_step.sv]
// ----------------------------------------------------------------------------
// vlrb_step
// Combinational update of the ring state for one request beat.
// ----------------------------------------------------------------------------
module vlrb_step (
	input  vlrb_pkg::vlrb_state_t           st,
	input  logic                            block_write,
	input  logic [vlrb_pkg::FUNC_W-1:0]     func,
	input  logic [vlrb_pkg::BYTES_W-1:0]    byte_count,
	input  logic                            end_request,
	output vlrb_pkg::vlrb_state_t           nx,
	output vlrb_pkg::status_t               status,
	output logic [vlrb_pkg::OFFSET_W-1:0]   offset
);
	import vlrb_pkg::*;

	localparam logic [SUM_W-1:0] BUF_S   = SUM_W'(BUF_BYTES);
	localparam logic [SUM_W-1:0] ALIGN_S = SUM_W'(ALIGN_BYTES);

	// Saturating add to the fill level
	function automatic logic [FILL_W-1:0] fill_add(input logic [SUM_W-1:0] f,
	                                               input logic [SUM_W-1:0] a);
		logic [SUM_W-1:0] s;
		s = f + a;
		return (s > BUF_S) ? FILL_W'(BUF_BYTES) : FILL_W'(s);
	endfunction

	// Subtract from the fill level, floored at zero
	function automatic logic [FILL_W-1:0] fill_sub(input logic [SUM_W-1:0] f,
	                                               input logic [SUM_W-1:0] a);
		return (a > f) ? '0 : FILL_W'(f - a);
	endfunction

	logic [SUM_W-1:0]    n;
	logic [SUM_W-1:0]    f;
	logic [SUM_W-1:0]    fa;
	logic [SUM_W-1:0]    rem;
	logic [SUM_W-1:0]    rsum;
	logic [PTR_W-1:0]    wo;
	logic [PTR_W-1:0]    ro;
	logic [OFFSET_W-1:0] off;
	status_t             full_code;

	always_comb begin
		nx        = st;
		status    = ST_OK;
		off       = '0;
		n         = SUM_W'(byte_count);
		f         = SUM_W'(st.fill);
		fa        = f;
		rem       = '0;
		rsum      = '0;
		wo        = '0;
		ro        = '0;
		full_code = block_write ? ST_FULL_WAIT : ST_FULL_DROP;

		case (func_t'(func))
			FN_SUBMIT: begin
				nx.fill = fill_add(f, n);
			end
			FN_ACQUIRE: begin
				if (st.halted) begin
					status = ST_TERM;
				end else begin
					wo  = (SUM_W'(st.wr_off) > BUF_S) ? '0 : st.wr_off;
					rem = BUF_S - SUM_W'(wo);
					// Tail too short for anything: count it as padding and wrap
					if (rem < ALIGN_S) begin
						if (f + n + rem > BUF_S) begin
							status = full_code;
						end else begin
							nx.fill = fill_add(f, rem);
							wo      = '0;
						end
					// Record does not fit the tail: place a rewind marker and wrap
					end else if (n > rem) begin
						if (f + ALIGN_S + n + rem > BUF_S) begin
							status = full_code;
						end else begin
							nx.mk_valid = 1'b1;
							nx.mk_off   = wo;
							nx.fill     = fill_add(f, ALIGN_S + rem);
							wo          = '0;
						end
					end else if (f + n > BUF_S) begin
						status = full_code;
					end
					nx.wr_off = wo;
					if (status == ST_OK) begin
						off       = wo[OFFSET_W-1:0];
						nx.wr_off = PTR_W'(SUM_W'(wo) + n);
					end
				end
			end
			FN_PEEK, FN_CONSUME: begin
				if (st.halted) begin
					status = ST_TERM;
				end else if (f == '0) begin
					status = ST_EMPTY;
				end else begin
					// Head alignment: skip padding tail or a pending rewind marker
					ro  = (SUM_W'(st.rd_off) > BUF_S) ? '0 : st.rd_off;
					rem = BUF_S - SUM_W'(ro);
					if (rem < ALIGN_S) begin
						ro = '0;
						fa = SUM_W'(fill_sub(f, rem));
					end else if (st.mk_valid && (st.mk_off == ro)) begin
						ro          = '0;
						nx.mk_valid = 1'b0;
						fa          = SUM_W'(fill_sub(f, ALIGN_S + rem));
					end
					nx.rd_off = ro;
					nx.fill   = FILL_W'(fa);
					if (fa == '0) begin
						status = ST_EMPTY;
					end else if (func_t'(func) == FN_PEEK) begin
						off = ro[OFFSET_W-1:0];
					end else begin
						off     = ro[OFFSET_W-1:0];
						nx.done = st.done + 1'b1;
						if (end_request) begin
							nx.halted = 1'b1;
							status    = ST_TERM;
						end else if (n > fa) begin
							nx.halted = 1'b1;
							status    = ST_OVERSIZE;
						end else begin
							rsum      = SUM_W'(ro) + n;
							nx.rd_off = (rsum > BUF_S) ? '0 : PTR_W'(rsum);
							nx.fill   = FILL_W'(fa - n);
						end
					end
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase

		offset = off;
	end

endmodule

[rtl/variable_length_ring_buffer_core.sv]
// ----------------------------------------------------------------------------
// variable_length_ring_buffer_core
// Space manager for a ring of variable-length aligned records.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid / in_stall) carries func, byte_count and
//   end_request. Functions: acquire a write offset, submit committed bytes,
//   peek the head record, consume the head record.
//   Response channel (out_valid / out_stall) returns one beat per request:
//   status, offset, fill_level and records_done.
//   cfg_we / cfg_wdata write block_write: 1 reports full as wait, 0 as dropped.
// Timing:
//   A request is captured in an input register; the ring state and the
//   response register update from it when the response register drains or
//   is empty. One request per cycle is sustained while out_stall is low; the
//   bound is the single add/compare pass over the state register.
// Reset:
//   All pointers, the fill level, the halt flag, the rewind marker and the
//   consumed count clear; block_write clears to 0. No responses are pending.
// Stall:
//   While out_stall holds a response, the held beat stays put; a request is
//   still taken into an empty input register, then in_stall rises.
// ----------------------------------------------------------------------------
module variable_length_ring_buffer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [vlrb_pkg::FUNC_W-1:0]     func,
	input  logic [vlrb_pkg::BYTES_W-1:0]    byte_count,
	input  logic                            end_request,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [vlrb_pkg::STATUS_W-1:0]   status,
	output logic [vlrb_pkg::OFFSET_W-1:0]   offset,
	output logic [vlrb_pkg::FILL_W-1:0]     fill_level,
	output logic [vlrb_pkg::DONE_W-1:0]     records_done
);
	import vlrb_pkg::*;

	logic                 block_write_q;
	vlrb_state_t          state_q;
	vlrb_state_t          state_nx;

	logic                 valid_s1;
	logic [FUNC_W-1:0]    func_s1;
	logic [BYTES_W-1:0]   bytes_s1;
	logic                 end_s1;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [OFFSET_W-1:0]  offset_q;
	logic [FILL_W-1:0]    fill_q;
	logic [DONE_W-1:0]    done_q;

	status_t              step_status;
	logic [OFFSET_W-1:0]  step_offset;
	logic                 advance;
	logic                 in_take;

	// Handshake: the response register drains or is empty
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_write_q <= 1'b0;
		end else if (cfg_we) begin
			block_write_q <= cfg_wdata;
		end
	end

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1  <= func;
			bytes_s1 <= byte_count;
			end_s1   <= end_request;
		end
	end

	vlrb_step u_step (
		.st          (state_q),
		.block_write (block_write_q),
		.func        (func_s1),
		.byte_count  (bytes_s1),
		.end_request (end_s1),
		.nx          (state_nx),
		.status      (step_status),
		.offset      (step_offset)
	);

	// Ring state and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nx;
			end
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			status_q <= STATUS_W'(step_status);
			offset_q <= step_offset;
			fill_q   <= state_nx.fill;
			done_q   <= state_nx.done;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign offset       = offset_q;
	assign fill_level   = fill_q;
	assign records_done = done_q;

endmodule

[rtl/vlrb_checker.sv]
// ----------------------------------------------------------------------------
// vlrb_checker
// Port-level assertions for the ring buffer core, bound to the top level.
// ----------------------------------------------------------------------------
`include "variable_length_ring_buffer_core_defines.svh"

module vlrb_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_stall,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [vlrb_pkg::STATUS_W-1:0]   status,
	input  logic [vlrb_pkg::OFFSET_W-1:0]   offset,
	input  logic [vlrb_pkg::FILL_W-1:0]     fill_level,
	input  logic [vlrb_pkg::DONE_W-1:0]     records_done
);
	import vlrb_pkg::*;

	// A stalled response beat holds
	`VLRB_ASSERT_NEXT(a_resp_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(offset) && $stable(fill_level) && $stable(records_done), "stalled response beat changed")

	// Fill level never exceeds the ring size
	`VLRB_ASSERT_SAME(a_fill_bound, clk, arst_n, out_valid, fill_level <= FILL_W'(BUF_BYTES), "fill level above ring size")

	// Full and empty responses carry no offset
	`VLRB_ASSERT_SAME(a_no_offset, clk, arst_n, out_valid && (status == ST_EMPTY || status == ST_FULL_WAIT || status == ST_FULL_DROP), offset == '0, "offset on full or empty response")

	// With no response waiting, requests are never stalled
	`VLRB_ASSERT_SAME(a_no_idle_stall, clk, arst_n, !out_valid, !in_stall, "request stalled with empty response register")

endmodule

bind variable_length_ring_buffer_core vlrb_checker u_vlrb_checker (.*);

[verif/variable_length_ring_buffer_core_checker.sv]
// ----------------------------------------------------------------------------
// variable_length_ring_buffer_core_checker
// Watches the request and response channels of the ring buffer core, keeps
// its own copy of the ring bookkeeping, predicts one response beat for every
// accepted request and compares each response beat field by field with the
// oldest prediction. Also publishes the predicted fill level at the head so
// the stimulus can size consumes without running into an oversize halt.
// ----------------------------------------------------------------------------
module variable_length_ring_buffer_core_checker
	import vlrb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [FUNC_W-1:0]   func,
	input  logic [BYTES_W-1:0]  byte_count,
	input  logic                end_request,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [STATUS_W-1:0] status,
	input  logic [OFFSET_W-1:0] offset,
	input  logic [FILL_W-1:0]   fill_level,
	input  logic [DONE_W-1:0]   records_done,
	output int                  fail_count,
	output int                  open_beats,
	output logic [FILL_W-1:0]   head_bytes
);
	timeunit 1ns;
	timeprecision 1ps;

	// Ring bookkeeping as the block should hold it
	typedef struct {
		logic [PTR_W-1:0]  wr;
		logic [PTR_W-1:0]  rd;
		logic [FILL_W-1:0] fill;
		logic              halted;
		logic              mk_valid;
		logic [PTR_W-1:0]  mk_off;
		logic [DONE_W-1:0] done;
	} ring_t;

	// One response beat
	typedef struct {
		status_t             status;
		logic [OFFSET_W-1:0] offset;
		logic [FILL_W-1:0]   fill;
		logic [DONE_W-1:0]   done;
	} ring_beat_t;

	ring_t      ring;
	logic       block_write;
	ring_beat_t expected_beats[$];

	// Fill level arithmetic: adds saturate at the ring size, subtracts stop at 0
	function automatic logic [FILL_W-1:0] fill_plus(logic [FILL_W-1:0] f, int unsigned n);
		return (f + n > BUF_BYTES) ? FILL_W'(BUF_BYTES) : FILL_W'(f + n);
	endfunction

	function automatic logic [FILL_W-1:0] fill_minus(logic [FILL_W-1:0] f, int unsigned n);
		return (n > f) ? '0 : FILL_W'(f - n);
	endfunction

	// Move the reader onto the head record: skip tail padding or a rewind marker
	function automatic ring_t head_align(ring_t s);
		int unsigned rr;
		if (s.fill != 0) begin
			if (s.rd > BUF_BYTES)
				s.rd = '0;
			rr = BUF_BYTES - s.rd;
			if (rr < ALIGN_BYTES) begin
				s.rd   = '0;
				s.fill = fill_minus(s.fill, rr);
			end else if (s.mk_valid && s.mk_off == s.rd) begin
				s.rd       = '0;
				s.mk_valid = 1'b0;
				s.fill     = fill_minus(s.fill, ALIGN_BYTES + rr);
			end
		end
		return s;
	endfunction

	// Apply one request to the ring and return the beat it must produce
	function automatic ring_beat_t predict_beat(func_t fn, int unsigned n, logic end_req);
		ring_beat_t  r;
		status_t     full_st;
		int unsigned rem;
		int unsigned rd_next;
		r.status = ST_OK;
		r.offset = '0;
		full_st  = block_write ? ST_FULL_WAIT : ST_FULL_DROP;
		if (fn == FN_SUBMIT) begin
			ring.fill = fill_plus(ring.fill, n);
		end else if (ring.halted) begin
			r.status = ST_TERM;
		end else if (fn == FN_ACQUIRE) begin
			if (ring.wr > BUF_BYTES)
				ring.wr = '0;
			rem = BUF_BYTES - ring.wr;
			if (rem < ALIGN_BYTES) begin
				// short tail becomes padding
				if (ring.fill + n + rem > BUF_BYTES) begin
					r.status = full_st;
				end else begin
					ring.fill = fill_plus(ring.fill, rem);
					ring.wr   = '0;
				end
			end else if (n > rem) begin
				// wrap behind a rewind marker, replacing any pending one
				if (ring.fill + ALIGN_BYTES + n + rem > BUF_BYTES) begin
					r.status = full_st;
				end else begin
					ring.mk_valid = 1'b1;
					ring.mk_off   = ring.wr;
					ring.fill     = fill_plus(ring.fill, ALIGN_BYTES + rem);
					ring.wr       = '0;
				end
			end else if (ring.fill + n > BUF_BYTES) begin
				r.status = full_st;
			end
			if (r.status == ST_OK) begin
				r.offset = ring.wr[OFFSET_W-1:0];
				ring.wr  = PTR_W'(ring.wr + n);
			end
		end else begin
			ring = head_align(ring);
			if (ring.fill == 0) begin
				r.status = ST_EMPTY;
			end else if (fn == FN_PEEK) begin
				r.offset = ring.rd[OFFSET_W-1:0];
			end else begin
				// consume: counted even when it halts the ring
				r.offset  = ring.rd[OFFSET_W-1:0];
				ring.done = ring.done + 1'b1;
				if (end_req) begin
					ring.halted = 1'b1;
					r.status    = ST_TERM;
				end else if (n > ring.fill) begin
					ring.halted = 1'b1;
					r.status    = ST_OVERSIZE;
				end else begin
					rd_next   = ring.rd + n;
					ring.rd   = (rd_next > BUF_BYTES) ? '0 : PTR_W'(rd_next);
					ring.fill = FILL_W'(ring.fill - n);
				end
			end
		end
		r.fill = ring.fill;
		r.done = ring.done;
		return r;
	endfunction

	function automatic int beat_field(string name, logic [15:0] want, logic [15:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		return 1;
	endfunction

	// Compare response beats first, then predict from the request beat
	always @(posedge clk or negedge arst_n) begin : watch
		ring_beat_t want;
		ring_t      settled;
		int         errs;
		if (!arst_n) begin
			ring = '{default: '0};
			block_write = 1'b0;
			expected_beats.delete();
			fail_count <= 0;
			open_beats <= 0;
			head_bytes <= '0;
		end else begin
			errs = 0;
			if (cfg_we)
				block_write = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: response beat with none expected: status %0d offset %0d fill %0d done %0d",
						$time, status, offset, fill_level, records_done);
					errs++;
				end else begin
					want = expected_beats.pop_front();
					errs += beat_field("status", want.status, status);
					errs += beat_field("offset", want.offset, offset);
					errs += beat_field("fill_level", want.fill, fill_level);
					errs += beat_field("records_done", want.done, records_done);
				end
			end
			if (in_valid && !in_stall) begin
				expected_beats.push_back(predict_beat(func_t'(func), byte_count, end_request));
				settled = head_align(ring);
				head_bytes <= settled.fill;
			end
			open_beats <= expected_beats.size();
			fail_count <= fail_count + errs;
		end
	end

endmodule

[verif/variable_length_ring_buffer_core_tb.sv]
// ----------------------------------------------------------------------------
// variable_length_ring_buffer_core_tb
// Drives acquire, submit, peek and consume requests into the ring buffer core
// with random gaps and response stalls, over several block_write settings.
// A directed opening covers empty, full, padding and marker cases; random
// produce/consume traffic follows; a closing sequence halts the ring.
// The checker beside the block predicts and compares every response beat.
// ----------------------------------------------------------------------------
module variable_length_ring_buffer_core_tb
	import vlrb_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 6;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_wdata;
	logic                in_valid;
	logic                in_stall;
	logic [FUNC_W-1:0]   func;
	logic [BYTES_W-1:0]  byte_count;
	logic                end_request;
	logic                out_valid;
	logic                out_stall;
	logic [STATUS_W-1:0] status;
	logic [OFFSET_W-1:0] offset;
	logic [FILL_W-1:0]   fill_level;
	logic [DONE_W-1:0]   records_done;

	int                  fail_count;
	int                  open_beats;
	logic [FILL_W-1:0]   head_bytes;

	int                  cycle_count;
	int unsigned         record_sizes[$];
	bit                  just_accepted;
	int                  burst_left;
	int                  beats_sent;
	bit                  hold_armed;
	bit                  hold_done;

	variable_length_ring_buffer_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.byte_count   (byte_count),
		.end_request  (end_request),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.offset       (offset),
		.fill_level   (fill_level),
		.records_done (records_done)
	);

	variable_length_ring_buffer_core_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.byte_count   (byte_count),
		.end_request  (end_request),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.offset       (offset),
		.fill_level   (fill_level),
		.records_done (records_done),
		.fail_count   (fail_count),
		.open_beats   (open_beats),
		.head_bytes   (head_bytes)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// Request gap: mostly none, some short, a few long, with gapless bursts
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 99) == 0) begin
			burst_left = $urandom_range(40, 120);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic pause(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
			just_accepted = 1'b0;
		end
	endtask

	// Offer one request beat and hold it until accepted
	task automatic send_beat(input func_t fn, input int unsigned n, input bit er);
		func        <= fn;
		byte_count  <= BYTES_W'(n);
		end_request <= er;
		in_valid    <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		just_accepted = 1'b1;
		beats_sent++;
		pause(pick_gap());
	endtask

	// Drop valid, wait for every response, then let the pipeline settle
	task automatic wait_idle();
		pause(1);
		while (open_beats != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_block_write(input bit v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// Consume the head record; when the predicted head fill is nonzero it caps
	// the size; that fill is registered and lags the beat just taken
	task automatic take_head(input bit with_peek);
		int unsigned avail;
		int unsigned n;
		if (with_peek)
			send_beat(FN_PEEK, $urandom_range(0, 8191), $urandom_range(0, 1));
		if (just_accepted)
			pause(1);
		avail = head_bytes;
		n = (record_sizes.size() != 0) ? record_sizes.pop_front() : ALIGN_BYTES;
		if ($urandom_range(0, 9) == 0)
			n = $urandom_range(0, avail);
		if (avail == 0)
			n = $urandom_range(0, 8191);
		else if (n > avail)
			n = avail;
		send_beat(FN_CONSUME, n, 1'b0);
	endtask

	// Produce/consume traffic, swinging between filling and draining the ring
	task automatic random_traffic(input int beats);
		int          first;
		int          pick;
		int          r;
		int unsigned n;
		bit          filling;
		first   = beats_sent;
		filling = 1'b1;
		while (beats_sent - first < beats) begin
			if ($urandom_range(0, 39) == 0)
				filling = !filling;
			pick = $urandom_range(0, 99);
			if (pick < (filling ? 60 : 25)) begin
				// acquire then submit one record
				r = $urandom_range(0, 99);
				if (r < 85)
					n = ALIGN_BYTES * $urandom_range(1, 32);
				else if (r < 97)
					n = ALIGN_BYTES * $urandom_range(33, 200);
				else
					n = $urandom_range(1, 300);
				send_beat(FN_ACQUIRE, n, $urandom_range(0, 1));
				send_beat(FN_SUBMIT, n, $urandom_range(0, 1));
				record_sizes.push_back(n);
			end else if (pick < 85) begin
				take_head($urandom_range(0, 1));
			end else begin
				// loose beats: odd sizes, oversize acquires, stray submits
				r = $urandom_range(0, 99);
				if (r < 70)
					n = $urandom_range(0, 256);
				else if (r < 90)
					n = $urandom_range(0, BUF_BYTES);
				else
					n = $urandom_range(0, 8191);
				case ($urandom_range(0, 3))
					0: send_beat(FN_ACQUIRE, n, $urandom_range(0, 1));
					1: send_beat(FN_SUBMIT, $urandom_range(0, 64), $urandom_range(0, 1));
					2: send_beat(FN_PEEK, n, $urandom_range(0, 1));
					default: take_head(1'b0);
				endcase
			end
		end
	endtask

	// Response side: random stalls plus one long hold-off
	initial begin : receiver
		int stall_len;
		int run_len;
		int hold_cycles;
		out_stall <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++)
					@(posedge clk);
				out_stall <= 1'b0;
			end else begin
				stall_len = $urandom_range(0, 99);
				if (stall_len < 60)
					stall_len = 0;
				else if (stall_len < 95)
					stall_len = $urandom_range(1, 3);
				else
					stall_len = $urandom_range(15, 40);
				if (stall_len > 0) begin
					out_stall <= 1'b1;
					repeat (stall_len) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
			run_len = ($urandom_range(0, 99) < 92) ? $urandom_range(1, 6) : $urandom_range(30, 120);
			repeat (run_len) @(posedge clk);
		end
	end

	// Stimulus and verdict
	initial begin : stimulus
		just_accepted = 1'b0;
		burst_left    = 0;
		beats_sent    = 0;
		hold_armed    = 1'b0;
		hold_done     = 1'b0;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= 1'b0;
		in_valid    <= 1'b0;
		func        <= FN_ACQUIRE;
		byte_count  <= '0;
		end_request <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty ring, records larger than the ring, whole-ring record
		send_beat(FN_PEEK, 0, 1'b0);
		send_beat(FN_CONSUME, ALIGN_BYTES, 1'b0);
		send_beat(FN_ACQUIRE, BUF_BYTES + 1, 1'b0);
		send_beat(FN_ACQUIRE, 8191, 1'b1);
		send_beat(FN_ACQUIRE, 0, 1'b0);
		send_beat(FN_ACQUIRE, BUF_BYTES, 1'b0);
		send_beat(FN_SUBMIT, BUF_BYTES, 1'b0);
		send_beat(FN_ACQUIRE, 8, 1'b0);
		send_beat(FN_SUBMIT, 8, 1'b1);
		send_beat(FN_PEEK, 0, 1'b0);
		send_beat(FN_CONSUME, BUF_BYTES, 1'b0);
		// zero-length tail wraps the writer, then the reader
		send_beat(FN_ACQUIRE, 16, 1'b0);
		send_beat(FN_SUBMIT, 16, 1'b0);
		send_beat(FN_PEEK, 0, 1'b0);
		send_beat(FN_CONSUME, 16, 1'b0);
		// rewind marker: refused while full, placed once space is freed
		send_beat(FN_ACQUIRE, 4064, 1'b0);
		send_beat(FN_SUBMIT, 4064, 1'b0);
		send_beat(FN_ACQUIRE, 24, 1'b0);
		send_beat(FN_CONSUME, 4064, 1'b0);
		send_beat(FN_ACQUIRE, 24, 1'b0);
		send_beat(FN_SUBMIT, 24, 1'b0);
		send_beat(FN_PEEK, 0, 1'b0);
		send_beat(FN_CONSUME, 24, 1'b0);

		// Random phases across block_write settings
		set_block_write(1'b1);
		random_traffic(520);
		set_block_write(1'b0);
		hold_armed = 1'b1;
		random_traffic(520);
		set_block_write(1'b1);
		random_traffic(520);

		// Fill the ring with the reader settled, then halt it
		send_beat(FN_SUBMIT, BUF_BYTES, 1'b0);
		send_beat(FN_PEEK, 0, 1'b0);
		send_beat(FN_SUBMIT, BUF_BYTES, 1'b1);
		if ($urandom_range(0, 1))
			send_beat(FN_CONSUME, $urandom_range(0, 8191), 1'b1);
		else
			send_beat(FN_CONSUME, $urandom_range(BUF_BYTES + 1, 8191), 1'b0);
		// halted ring: only submit still counts
		send_beat(FN_ACQUIRE, 8, 1'b0);
		send_beat(FN_PEEK, 0, 1'b0);
		send_beat(FN_CONSUME, 8, 1'b1);
		send_beat(FN_SUBMIT, 100, 1'b0);
		send_beat(FN_ACQUIRE, 0, 1'b1);

		wait_idle();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/vlrb_pkg.sv
rtl/vlrb_step.sv
rtl/variable_length_ring_buffer_core.sv
rtl/vlrb_checker.sv
verif/variable_length_ring_buffer_core_checker.sv
verif/variable_length_ring_buffer_core_tb.sv
